// ===== hdl/rbbm_pkg.sv =====
// Shared types and codes for the break-before-make relay interlock.
package rbbm_pkg;

   localparam int unsigned TimeWidth = 32;

   typedef logic [TimeWidth-1:0] ms_type;

   // Relay select codes; values above spare never arise.
   typedef enum logic [2:0] {
      RELAY_NONE  = 3'd0,
      RELAY_HEAT  = 3'd1,
      RELAY_COOL  = 3'd2,
      RELAY_FAN   = 3'd3,
      RELAY_SPARE = 3'd4
   } relay_type;

   // Configuration register indexes.
   typedef enum logic [0:0] {
      CSR_HEAT_WAIT  = 1'b0,
      CSR_OTHER_WAIT = 1'b1
   } csr_index_type;

   // One request as held in the input register.
   typedef struct packed {
      ms_type now_ms;
      logic   want_heat;
      logic   want_cool;
      logic   want_fan;
      logic   want_spare;
      logic   shutoff;
   } req_item_type;

   // Relay drive pattern, one-hot or all zero.
   typedef struct packed {
      logic heat;
      logic cool;
      logic fan;
      logic spare;
   } drive_type;

endpackage

// ===== hdl/rbbm_ctrl.sv =====
// Interlock state and decision logic: one request per advance.
module rbbm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  rbbm_pkg::req_item_type item,
   input  rbbm_pkg::ms_type      heat_wait_ms,
   input  rbbm_pkg::ms_type      other_wait_ms,
   output rbbm_pkg::drive_type   drive
);
   import rbbm_pkg::*;

   relay_type active_ff, active_in;
   relay_type pending_ff, pending_in;
   ms_type    start_ff, start_in;

   relay_type req;
   relay_type drive_sel;
   ms_type    elapsed;
   ms_type    wait_ms;

   always_comb begin
      priority if (item.shutoff)   req = RELAY_NONE;
      else if (item.want_heat)     req = RELAY_HEAT;
      else if (item.want_cool)     req = RELAY_COOL;
      else if (item.want_fan)      req = RELAY_FAN;
      else if (item.want_spare)    req = RELAY_SPARE;
      else                         req = RELAY_NONE;
   end

   // Wrapping elapsed time; pending is never none where this is used.
   assign elapsed = item.now_ms - start_ff;
   assign wait_ms = (pending_ff == RELAY_HEAT) ? heat_wait_ms : other_wait_ms;

   always_comb begin
      active_in  = active_ff;
      pending_in = pending_ff;
      start_in   = start_ff;
      drive_sel  = RELAY_NONE;
      priority if (req == RELAY_NONE) begin
         active_in  = RELAY_NONE;
         pending_in = RELAY_NONE;
         start_in   = '0;
      end else if (req == active_ff) begin
         pending_in = RELAY_NONE;
         start_in   = '0;
         drive_sel  = active_ff;
      end else if (active_ff == RELAY_NONE && pending_ff == RELAY_NONE) begin
         // fully idle: energize at once
         active_in = req;
         drive_sel = req;
      end else if (pending_ff != req) begin
         // break first, restart the interlock timer
         pending_in = req;
         start_in   = item.now_ms;
         active_in  = RELAY_NONE;
      end else if (elapsed < wait_ms) begin
         drive_sel = RELAY_NONE;
      end else begin
         active_in  = pending_ff;
         pending_in = RELAY_NONE;
         start_in   = '0;
         drive_sel  = pending_ff;
      end
   end

   assign drive.heat  = (drive_sel == RELAY_HEAT);
   assign drive.cool  = (drive_sel == RELAY_COOL);
   assign drive.fan   = (drive_sel == RELAY_FAN);
   assign drive.spare = (drive_sel == RELAY_SPARE);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= RELAY_NONE;
         pending_ff <= RELAY_NONE;
         start_ff   <= '0;
      end else if (advance) begin
         active_ff  <= active_in;
         pending_ff <= pending_in;
         start_ff   <= start_in;
      end
   end

endmodule

// ===== hdl/relay_break_before_make_interlock_unit.sv =====
// Top level of the break-before-make relay interlock: ports, CSRs and pipeline registers.
//
// Drives at most one of four relays (heat, cool, fan, spare) from timestamped
// demand requests. Demands are priority-encoded, heat highest. Switching to a
// different relay drops all drives first; the new relay energizes only once its
// interlock wait (heat_wait_ms for heat, other_wait_ms otherwise) has elapsed
// on the wrapping millisecond clock carried in the request, and only on a
// request that repeats the demand. From a fully idle state the relay energizes
// at once. shutoff drops everything and clears any pending switch.
// Every request yields exactly one response. Throughput is one request per
// clock unless rsp_stall holds it back; input register, then response register,
// with the interlock decision between them. req_stall follows rsp_stall only
// while both registers are full. Write the wait registers only while idle.
module relay_break_before_make_interlock_unit (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  rbbm_pkg::ms_type       req_now_ms,
   input  logic                   req_want_heat,
   input  logic                   req_want_cool,
   input  logic                   req_want_fan,
   input  logic                   req_want_spare,
   input  logic                   req_shutoff,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_drive_heat,
   output logic                   rsp_drive_cool,
   output logic                   rsp_drive_fan,
   output logic                   rsp_drive_spare,
   // configuration writes
   input  logic                   csr_write_en,
   input  rbbm_pkg::csr_index_type csr_index,
   input  rbbm_pkg::ms_type       csr_wdata
);
   import rbbm_pkg::*;

   ms_type       heat_wait_ff;
   ms_type       other_wait_ff;

   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         out_valid_ff;
   drive_type    out_drive_ff;

   drive_type    drive;
   logic         out_free;
   logic         advance;
   logic         take;

   // Response register can load when empty or being drained this cycle.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   // Input register loads when empty or when its request moves on.
   assign req_stall = in_valid_ff && !out_free;
   assign take      = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         heat_wait_ff  <= '0;
         other_wait_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_HEAT_WAIT:  heat_wait_ff  <= csr_wdata;
            CSR_OTHER_WAIT: other_wait_ff <= csr_wdata;
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_item_ff.now_ms     <= req_now_ms;
         in_item_ff.want_heat  <= req_want_heat;
         in_item_ff.want_cool  <= req_want_cool;
         in_item_ff.want_fan   <= req_want_fan;
         in_item_ff.want_spare <= req_want_spare;
         in_item_ff.shutoff    <= req_shutoff;
      end
   end

   rbbm_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .item          (in_item_ff),
      .heat_wait_ms  (heat_wait_ff),
      .other_wait_ms (other_wait_ff),
      .drive         (drive)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_drive_ff <= drive;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_drive_heat  = out_drive_ff.heat;
   assign rsp_drive_cool  = out_drive_ff.cool;
   assign rsp_drive_fan   = out_drive_ff.fan;
   assign rsp_drive_spare = out_drive_ff.spare;

endmodule

// ===== tb/tb_relay_break_before_make_interlock_unit.sv =====
// Testbench for the break-before-make relay interlock: directed and random request traffic.
module tb_relay_break_before_make_interlock_unit;
   import rbbm_pkg::*;

   // Cycles with no handshake on either channel before the run is abandoned.
   localparam int unsigned IdleLimit   = 1000;
   // Settle time once the response queue is empty; the unit is two stages deep.
   localparam int unsigned DrainCycles = 4;

   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic                  req_stall;
   ms_type                req_now_ms     = '0;
   logic                  req_want_heat  = 1'b0;
   logic                  req_want_cool  = 1'b0;
   logic                  req_want_fan   = 1'b0;
   logic                  req_want_spare = 1'b0;
   logic                  req_shutoff    = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall      = 1'b0;
   logic                  rsp_drive_heat;
   logic                  rsp_drive_cool;
   logic                  rsp_drive_fan;
   logic                  rsp_drive_spare;
   logic                  csr_write_en   = 1'b0;
   csr_index_type         csr_index      = CSR_HEAT_WAIT;
   ms_type                csr_wdata      = '0;

   // Interlock state as the unit should hold it, plus our copy of the wait registers.
   relay_type             lit_relay        = RELAY_NONE;
   relay_type             waiting_relay    = RELAY_NONE;
   ms_type                waiting_since_ms = '0;
   ms_type                heat_delay_ms    = '0;
   ms_type                other_delay_ms   = '0;

   drive_type             expected_drives[$];
   drive_type             oldest_drive;
   int unsigned           error_count      = 0;
   int unsigned           idle_cycles      = 0;
   int unsigned           send_idle_pct    = 0;
   int unsigned           rsp_stall_pct    = 0;

   relay_break_before_make_interlock_unit uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_now_ms      (req_now_ms),
      .req_want_heat   (req_want_heat),
      .req_want_cool   (req_want_cool),
      .req_want_fan    (req_want_fan),
      .req_want_spare  (req_want_spare),
      .req_shutoff     (req_shutoff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_drive_heat  (rsp_drive_heat),
      .rsp_drive_cool  (rsp_drive_cool),
      .rsp_drive_fan   (rsp_drive_fan),
      .rsp_drive_spare (rsp_drive_spare),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Advance the interlock by one request and return the drive pattern it must produce.
   function automatic drive_type next_drive(input req_item_type item);
      relay_type demand;
      relay_type shown;
      ms_type    elapsed;
      ms_type    needed;
      drive_type pattern;
      // shutoff beats everything; otherwise fixed priority heat > cool > fan > spare
      if (item.shutoff)         demand = RELAY_NONE;
      else if (item.want_heat)  demand = RELAY_HEAT;
      else if (item.want_cool)  demand = RELAY_COOL;
      else if (item.want_fan)   demand = RELAY_FAN;
      else if (item.want_spare) demand = RELAY_SPARE;
      else                      demand = RELAY_NONE;
      shown = RELAY_NONE;
      if (demand == RELAY_NONE) begin
         lit_relay        = RELAY_NONE;
         waiting_relay    = RELAY_NONE;
         waiting_since_ms = '0;
      end else if (demand == lit_relay) begin
         // already on: any switch in progress is abandoned
         waiting_relay    = RELAY_NONE;
         waiting_since_ms = '0;
         shown            = lit_relay;
      end else if (lit_relay == RELAY_NONE && waiting_relay == RELAY_NONE) begin
         // fully idle, nothing to break first
         lit_relay = demand;
         shown     = demand;
      end else if (waiting_relay != demand) begin
         // break now, restart the interlock timer for the new target
         waiting_relay    = demand;
         waiting_since_ms = item.now_ms;
         lit_relay        = RELAY_NONE;
      end else begin
         // same target repeated: make once the wait has run out (wrapping ms clock)
         elapsed = item.now_ms - waiting_since_ms;
         needed  = (waiting_relay == RELAY_HEAT) ? heat_delay_ms : other_delay_ms;
         if (elapsed >= needed) begin
            lit_relay        = waiting_relay;
            waiting_relay    = RELAY_NONE;
            waiting_since_ms = '0;
            shown            = lit_relay;
         end
      end
      pattern.heat  = (shown == RELAY_HEAT);
      pattern.cool  = (shown == RELAY_COOL);
      pattern.fan   = (shown == RELAY_FAN);
      pattern.spare = (shown == RELAY_SPARE);
      return pattern;
   endfunction

   function automatic void check_drive_bit(input string name, input logic want_bit,
                                           input logic got_bit);
      if (got_bit !== want_bit) begin
         $display("%0t: %s expected %b actual %b", $time, name, want_bit, got_bit);
         error_count++;
      end
   endfunction

   // Response side: every accepted response is matched against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_drives.size() == 0) begin
            $display("%0t: unexpected response, expected none actual %b%b%b%b", $time,
                     rsp_drive_heat, rsp_drive_cool, rsp_drive_fan, rsp_drive_spare);
            error_count++;
         end else begin
            oldest_drive = expected_drives.pop_front();
            check_drive_bit("drive_heat", oldest_drive.heat, rsp_drive_heat);
            check_drive_bit("drive_cool", oldest_drive.cool, rsp_drive_cool);
            check_drive_bit("drive_fan", oldest_drive.fan, rsp_drive_fan);
            check_drive_bit("drive_spare", oldest_drive.spare, rsp_drive_spare);
         end
      end
   end

   // Random backpressure on the response channel at the current phase's rate.
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // Hang detection: too long without any handshake ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IdleLimit) begin
         $display("relay_break_before_make_interlock_unit: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offer one request, with random lead-in gaps, and predict its response on acceptance.
   task automatic send_request(input ms_type now_ms, input logic heat, input logic cool,
                               input logic fan, input logic spare, input logic off);
      req_item_type item;
      item.now_ms     = now_ms;
      item.want_heat  = heat;
      item.want_cool  = cool;
      item.want_fan   = fan;
      item.want_spare = spare;
      item.shutoff    = off;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_now_ms     <= now_ms;
      req_want_heat  <= heat;
      req_want_cool  <= cool;
      req_want_fan   <= fan;
      req_want_spare <= spare;
      req_shutoff    <= off;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      expected_drives.push_back(next_drive(item));
   endtask

   // Stop sending and hold off until every predicted response is back.
   task automatic drain_requests();
      req_valid <= 1'b0;
      while (expected_drives.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_wait(input csr_index_type index, input ms_type value);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
      if (index == CSR_HEAT_WAIT) heat_delay_ms = value;
      else other_delay_ms = value;
   endtask

   // Wait registers only change with the unit idle.
   task automatic set_waits(input ms_type heat_ms, input ms_type other_ms);
      drain_requests();
      write_wait(CSR_HEAT_WAIT, heat_ms);
      write_wait(CSR_OTHER_WAIT, other_ms);
   endtask

   // Zero waits (reset values): priority encoding, immediate make from idle, force off.
   task automatic test_priority_and_force_off();
      send_request(32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0); // no demand
      send_request(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0); // heat wins, on from idle
      send_request(32'h0000_0000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0); // same relay held
      send_request(32'h0000_0001, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0); // cool: break first
      send_request(32'h0000_0001, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0); // zero wait, repeat makes
      send_request(32'h0000_0002, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0); // fan pending
      send_request(32'h0000_0003, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0); // target changes to spare
      send_request(32'h0000_0003, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
      send_request(32'h0000_0004, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1); // force off over all demands
      send_request(32'h0000_0005, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0); // idle again, fan at once
      send_request(32'h0000_0006, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
   endtask

   // Nonzero and extreme waits, elapsed time across the 32-bit wrap and running backwards.
   task automatic test_interlock_waits();
      set_waits(32'd100, 32'hFFFF_FFFF);
      send_request(32'hFFFF_FFF0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0); // heat from idle
      send_request(32'hFFFF_FFF8, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0); // cool pending
      send_request(32'h0000_0010, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0); // far short of max wait
      send_request(32'hFFFF_FFF7, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0); // backwards: elapsed = max
      send_request(32'hFFFF_FFF0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0); // heat pending
      send_request(32'h0000_0053, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0); // 99 ms across the wrap
      send_request(32'h0000_0054, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0); // exactly 100 ms
      send_request(32'h0000_0060, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0); // fan pending
      send_request(32'h0000_0061, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0); // retarget restarts timer
      send_request(32'h0000_0062, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1); // force off clears pending
      send_request(32'h0000_0063, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0); // spare from idle
      set_waits(32'hFFFF_FFFF, 32'd0);
      send_request(32'h0000_0064, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0); // heat waits the max
      send_request(32'h0000_0065, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      send_request(32'h0000_0066, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0); // cool pending
      send_request(32'h0000_0066, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0); // zero other wait
   endtask

   // Bursts of one to eight requests that hold one target, with some noise mixed in.
   task automatic test_random_traffic(input int unsigned send_pct, input int unsigned stall_pct,
                                      input ms_type heat_ms, input ms_type other_ms,
                                      input int unsigned count);
      ms_type      stamp;
      logic [2:0]  target;
      logic [3:0]  wants;
      logic        off;
      int unsigned sent;
      set_waits(heat_ms, other_ms);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      stamp = $urandom;
      sent  = 0;
      while (sent < count) begin
         target = 3'($urandom_range(4));
         repeat ($urandom_range(1, 8)) begin
            wants = 4'($urandom_range(15));
            off   = 1'b0;
            if ($urandom_range(7) == 0) begin
               off = ($urandom_range(3) == 0);
            end else begin
               // the target's demand is set, lower priorities are don't-care
               case (target)
                  RELAY_HEAT:  wants[3] = 1'b1;
                  RELAY_COOL:  wants[3:2] = 2'b01;
                  RELAY_FAN:   wants[3:1] = 3'b001;
                  RELAY_SPARE: wants = 4'b0001;
                  default:     off = |wants;
               endcase
            end
            send_request(stamp, wants[3], wants[2], wants[1], wants[0], off);
            sent++;
            case ($urandom_range(31))
               0:       stamp = $urandom;
               1:       stamp = stamp - $urandom_range(1, 30);
               default: stamp = stamp + $urandom_range(0, 15);
            endcase
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_priority_and_force_off();
      test_interlock_waits();
      test_random_traffic(0, 0, 32'd0, 32'd0, 160);
      test_random_traffic(50, 0, $urandom_range(0, 40), $urandom_range(0, 40), 160);
      test_random_traffic(0, 50, $urandom_range(0, 40), $urandom_range(0, 40), 160);
      test_random_traffic(37, 37, $urandom_range(0, 40), $urandom_range(0, 40), 160);
      drain_requests();
      if (error_count == 0 && expected_drives.size() == 0) begin
         $display("relay_break_before_make_interlock_unit: match");
      end else begin
         $display("relay_break_before_make_interlock_unit: mismatch");
      end
      $finish;
   end

endmodule
